### src/bsme_pkg.sv
`timescale 1ns / 1ps

package bsme_pkg;

  // Default number of stack entries.
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Decimal conversion constants.
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] DEC_BASE   = 8'd10;
  localparam logic [7:0] DEC_MAX    = 8'd9;

  // Results per instruction at most.
  localparam int unsigned MAX_RES = 3;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_PUSH    = 3'd1,
    OP_EMIT    = 3'd2,
    OP_HALT    = 3'd3,
    OP_EMITDEC = 3'd4,
    OP_ADD     = 3'd5,
    OP_SWAP    = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_HALTED = 2'd1,
    KIND_UNDER  = 2'd2,
    KIND_OVER   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } result_t;

  // Results of one instruction, in delivery order from entry zero.
  typedef struct packed {
    logic [1:0]            num;
    result_t [MAX_RES-1:0] res;
  } res_bundle_t;

  typedef struct packed {
    logic [1:0] num;
    logic [7:0] d_hi;
    logic [7:0] d_mid;
    logic [7:0] d_lo;
  } dec_t;

  // Split a byte into ASCII decimal digits, most significant first in d_hi
  // when three digits are present. Tens use a multiply by 205/2048, which is
  // exact for values below 100.
  function automatic dec_t byte_to_dec(input logic [7:0] v);
    dec_t        d;
    logic [1:0]  hund;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    if (v >= 8'd200) begin
      hund = 2'd2;
      rem  = v - 8'd200;
    end else if (v >= 8'd100) begin
      hund = 2'd1;
      rem  = v - 8'd100;
    end else begin
      hund = 2'd0;
      rem  = v;
    end
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = rem - 8'(tens * DEC_BASE);
    if (hund != 2'd0) begin
      d.num   = 2'd3;
      d.d_hi  = 8'(hund) + ASCII_ZERO;
      d.d_mid = 8'(tens) + ASCII_ZERO;
      d.d_lo  = ones + ASCII_ZERO;
    end else if (v > DEC_MAX) begin
      d.num   = 2'd2;
      d.d_hi  = 8'(tens) + ASCII_ZERO;
      d.d_mid = ones + ASCII_ZERO;
      d.d_lo  = 8'd0;
    end else begin
      d.num   = 2'd1;
      d.d_hi  = ones + ASCII_ZERO;
      d.d_mid = 8'd0;
      d.d_lo  = 8'd0;
    end
    return d;
  endfunction

endpackage

### src/bsme_if.sv
`timescale 1ns / 1ps

// Instruction channel.
interface bsme_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] immediate;

  modport source (output valid, output func, output immediate, input ready);
  modport sink (input valid, input func, input immediate, output ready);
endinterface

// Result channel.
interface bsme_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output kind, output out_char, output last, input ready);
  modport sink (input valid, input kind, input out_char, input last, output ready);
endinterface

### src/bsme_ram.sv
`timescale 1ns / 1ps

module bsme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/bsme_core.sv
`timescale 1ns / 1ps

module bsme_core #(
  parameter int unsigned STACK_DEPTH = bsme_pkg::STACK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [2:0]            func,
  input  logic [7:0]            immediate,
  output bsme_pkg::res_bundle_t bundle
);
  import bsme_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // The top two entries live in registers; deeper entries live in the RAM.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    top_r, top_nxt;
  logic [7:0]    sec_r, sec_nxt;
  logic          halt_r, halt_nxt;
  logic          byp_v_r, byp_v_nxt;
  logic [7:0]    byp_d_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    third;
  op_t           op;
  dec_t          dec;

  bsme_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sec_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Third entry from the top: the RAM keeps it prefetched, except right after
  // a push wrote that same address.
  assign third = byp_v_r ? byp_d_r : ram_rdata;

  assign op  = op_t'(func);
  assign dec = byte_to_dec(top_r);

  // Instruction execution.
  always_comb begin
    cnt_nxt    = cnt_r;
    top_nxt    = top_r;
    sec_nxt    = sec_r;
    halt_nxt   = halt_r;
    ram_we     = 1'b0;
    ram_waddr  = AW'(cnt_r - CW'(2));
    bundle     = '0;
    if (accept && !halt_r) begin
      case (op)
        OP_PUSH: begin
          if (cnt_r == CW'(STACK_DEPTH)) begin
            bundle.num         = 2'd1;
            bundle.res[0].kind = KIND_OVER;
            bundle.res[0].last = 1'b1;
          end else begin
            ram_we  = (cnt_r >= CW'(2));
            top_nxt = immediate;
            sec_nxt = top_r;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        OP_EMIT: begin
          bundle.num         = 2'd1;
          bundle.res[0].last = 1'b1;
          if (cnt_r == '0) begin
            bundle.res[0].kind = KIND_UNDER;
          end else begin
            bundle.res[0].kind = KIND_CHAR;
            bundle.res[0].ch   = top_r;
            top_nxt = sec_r;
            sec_nxt = third;
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        OP_HALT: begin
          halt_nxt           = 1'b1;
          bundle.num         = 2'd1;
          bundle.res[0].kind = KIND_HALTED;
          bundle.res[0].last = 1'b1;
        end
        OP_EMITDEC: begin
          if (cnt_r == '0) begin
            bundle.num         = 2'd1;
            bundle.res[0].kind = KIND_UNDER;
            bundle.res[0].last = 1'b1;
          end else begin
            bundle.num         = dec.num;
            bundle.res[0].kind = KIND_CHAR;
            bundle.res[1].kind = KIND_CHAR;
            bundle.res[2].kind = KIND_CHAR;
            bundle.res[0].ch   = dec.d_hi;
            bundle.res[1].ch   = dec.d_mid;
            bundle.res[2].ch   = dec.d_lo;
            bundle.res[0].last = (dec.num == 2'd1);
            bundle.res[1].last = (dec.num == 2'd2);
            bundle.res[2].last = (dec.num == 2'd3);
            top_nxt = sec_r;
            sec_nxt = third;
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        OP_ADD, OP_SWAP: begin
          if (cnt_r < CW'(2)) begin
            bundle.num         = 2'd1;
            bundle.res[0].kind = KIND_UNDER;
            bundle.res[0].last = 1'b1;
          end else if (op == OP_ADD) begin
            top_nxt = top_r + sec_r;
            sec_nxt = third;
            cnt_nxt = cnt_r - CW'(1);
          end else begin
            top_nxt = sec_r;
            sec_nxt = top_r;
          end
        end
        default: begin
          bundle = '0;
        end
      endcase
    end
  end

  // Prefetch the entry that will be third from the top next cycle.
  assign ram_raddr = AW'(cnt_nxt - CW'(3));
  assign byp_v_nxt = ram_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      halt_r  <= 1'b0;
      byp_v_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      halt_r  <= halt_nxt;
      byp_v_r <= byp_v_nxt;
    end
    top_r   <= top_nxt;
    sec_r   <= sec_nxt;
    byp_d_r <= sec_r;
  end

`ifndef SYNTHESIS
  a_reset_state: assert property (@(posedge clk) !rst_n |=> (cnt_r == '0) && !halt_r)
    else $error("stack not empty or halted after reset");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n) halt_r |=> halt_r)
    else $error("halt cleared without reset");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!accept || halt_r) |=> $stable(cnt_r))
    else $error("stack count moved without an instruction");
`endif

endmodule

### src/bsme_outbuf.sv
`timescale 1ns / 1ps

module bsme_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  bsme_pkg::res_bundle_t bundle,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bsme_pkg::result_t     out_res
);
  import bsme_pkg::*;

  // Pending results, head in entry zero.
  logic [1:0] pend_r, pend_nxt;
  result_t    q_r [MAX_RES];
  result_t    q_nxt [MAX_RES];
  logic       pop;
  logic       do_load;

  assign out_valid = (pend_r != 2'd0);
  assign out_res   = q_r[0];
  assign pop       = out_valid && out_ready;
  // Room for a new instruction once the queue drains this cycle.
  assign free      = (pend_r == 2'd0) || ((pend_r == 2'd1) && out_ready);
  assign do_load   = load && (bundle.num != 2'd0);

  // Load a fresh group of results or shift toward the head.
  always_comb begin
    pend_nxt = pend_r;
    q_nxt    = q_r;
    if (do_load) begin
      pend_nxt = bundle.num;
      q_nxt[0] = bundle.res[0];
      q_nxt[1] = bundle.res[1];
      q_nxt[2] = bundle.res[2];
    end else if (pop) begin
      pend_nxt = pend_r - 2'd1;
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
    q_r <= q_nxt;
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n) do_load |-> free)
    else $error("results loaded over pending results");
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd1) |-> q_r[0].last)
    else $error("final pending result not marked last");
  a_head_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd2 || pend_r == 2'd3) |-> !q_r[0].last)
    else $error("result marked last before the group ends");
`endif

endmodule

### src/byte_stack_machine_executor_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload
// in_if     sink       func[2:0], immediate[7:0]
// out_if    source     kind[1:0], out_char[7:0], last
//
// One instruction executes per cycle while the result queue has room; the stack's
// top two entries sit in registers and the RAM read port prefetches the third.
// Results appear in the cycle after their instruction is taken. Every instruction,
// with or without results, is taken only once the queue is empty or its single
// result leaves that cycle, so three decimal digits hold the next until two leave.
// Reset is synchronous and active low; it empties the stack and clears the halt.
module byte_stack_machine_executor_top #(
  parameter int unsigned STACK_DEPTH = bsme_pkg::STACK_DEPTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  bsme_in_if.sink    in_if,
  bsme_out_if.source out_if
);
  import bsme_pkg::*;

  res_bundle_t bundle;
  result_t     out_res;
  logic        free;
  logic        accept;

  assign in_if.ready = free;
  assign accept      = in_if.valid && free;

  bsme_core #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_if.func),
    .immediate (in_if.immediate),
    .bundle    (bundle)
  );

  bsme_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .bundle    (bundle),
    .free      (free),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (out_res)
  );

  assign out_if.kind     = out_res.kind;
  assign out_if.out_char = out_res.ch;
  assign out_if.last     = out_res.last;

endmodule

### verif/byte_stack_machine_executor_top_tb.sv
`timescale 1ns / 1ps

module byte_stack_machine_executor_top_tb;
  import bsme_pkg::*;

  localparam int unsigned DEPTH       = STACK_DEPTH_DEF;
  localparam logic [2:0]  OP_UNUSED   = 3'd7;
  localparam int unsigned RUN_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned TAIL_CYCLES = 30;

  typedef struct {
    logic [2:0] func;
    logic [7:0] imm;
    bit         wait_idle;
  } instr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bsme_in_if  in_ch ();
  bsme_out_if out_ch ();

  byte_stack_machine_executor_top #(
    .STACK_DEPTH(DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // Instructions waiting to be offered, and characters and flags still owed.
  instr_t  pending_instrs[$];
  result_t due_results[$];

  // Shadow copy of the machine state.
  logic [7:0]  model_stack[DEPTH];
  int unsigned model_depth;
  bit          model_halted;

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned items_taken;
  int unsigned item_total;
  int unsigned press_start;
  int unsigned gen_depth;
  bit          next_waits;

  int unsigned src_gap;
  int unsigned src_calm;
  int unsigned snk_gap;
  int unsigned snk_calm;
  int unsigned hold_left;
  bit          hold_done;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle count and the run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) begin
      $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
    end
    err_cnt++;
  endtask

  function automatic void owe_result(input kind_t k, input logic [7:0] c, input logic l);
    result_t r;
    r.kind = k;
    r.ch   = c;
    r.last = l;
    due_results.push_back(r);
  endfunction

  // Work out the results of one accepted instruction and update the shadow state.
  function automatic void execute_instr(input logic [2:0] fn, input logic [7:0] imm);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] v;
    if (model_halted) begin
      return;
    end
    case (fn)
      OP_PUSH: begin
        if (model_depth >= DEPTH) begin
          owe_result(KIND_OVER, 8'd0, 1'b1);
        end else begin
          model_stack[model_depth] = imm;
          model_depth++;
        end
      end
      OP_EMIT: begin
        if (model_depth == 0) begin
          owe_result(KIND_UNDER, 8'd0, 1'b1);
        end else begin
          model_depth--;
          owe_result(KIND_CHAR, model_stack[model_depth], 1'b1);
        end
      end
      OP_HALT: begin
        model_halted = 1'b1;
        owe_result(KIND_HALTED, 8'd0, 1'b1);
      end
      OP_EMITDEC: begin
        if (model_depth == 0) begin
          owe_result(KIND_UNDER, 8'd0, 1'b1);
        end else begin
          model_depth--;
          v = model_stack[model_depth];
          // Digits go out most significant first, with no leading zeros.
          if (v >= DEC_BASE * DEC_BASE) begin
            owe_result(KIND_CHAR, ASCII_ZERO + v / (DEC_BASE * DEC_BASE), 1'b0);
            owe_result(KIND_CHAR, ASCII_ZERO + (v / DEC_BASE) % DEC_BASE, 1'b0);
          end else if (v > DEC_MAX) begin
            owe_result(KIND_CHAR, ASCII_ZERO + v / DEC_BASE, 1'b0);
          end
          owe_result(KIND_CHAR, ASCII_ZERO + v % DEC_BASE, 1'b1);
        end
      end
      OP_ADD, OP_SWAP: begin
        if (model_depth < 2) begin
          owe_result(KIND_UNDER, 8'd0, 1'b1);
        end else begin
          a = model_stack[model_depth - 1];
          b = model_stack[model_depth - 2];
          if (fn == OP_ADD) begin
            model_stack[model_depth - 2] = a + b;
            model_depth--;
          end else begin
            model_stack[model_depth - 1] = b;
            model_stack[model_depth - 2] = a;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Queue one instruction and follow the stack depth it leaves behind.
  function automatic void add_instr(input logic [2:0] fn, input logic [7:0] imm);
    instr_t it;
    it.func      = fn;
    it.imm       = imm;
    it.wait_idle = next_waits;
    next_waits   = 1'b0;
    pending_instrs.push_back(it);
    case (fn)
      OP_PUSH: if (gen_depth < DEPTH) gen_depth++;
      OP_EMIT, OP_EMITDEC: if (gen_depth > 0) gen_depth--;
      OP_ADD: if (gen_depth >= 2) gen_depth--;
      default: begin
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly short idle gaps, a few long ones, and now and then a calm stretch.
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end else if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(15, 40);
  endfunction

  // Instruction driver.
  always @(posedge clk) begin
    instr_t it;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.func      <= OP_NOP;
      in_ch.immediate <= 8'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        execute_instr(in_ch.func, in_ch.immediate);
        items_taken++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Keep offering the same item.
      end else if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_instrs.size() != 0 &&
                   !(pending_instrs[0].wait_idle && due_results.size() != 0)) begin
        it = pending_instrs.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.func      <= it.func;
        in_ch.immediate <= it.imm;
        src_gap = idle_len(src_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once the back-to-back stretch begins.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_taken >= press_start) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d char %0d last %0d",
                                    out_ch.kind, out_ch.out_char, out_ch.last));
        end else begin
          want = due_results.pop_front();
          if (out_ch.kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", out_ch.kind, want.kind));
          end
          if (out_ch.out_char !== want.ch) begin
            report_mismatch($sformatf("out_char %0d, expected %0d", out_ch.out_char, want.ch));
          end
          if (out_ch.last !== want.last) begin
            report_mismatch($sformatf("last %0d, expected %0d", out_ch.last, want.last));
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        snk_gap = idle_len(snk_calm);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned r;
    int unsigned seg;
    int unsigned thr;
    logic [2:0]  fn;
    bit          press_done;

    press_start     = 32'hFFFF_FFFF;
    press_done      = 1'b0;

    // Directed: underflow on each popping opcode, swap, add wrap, digit counts.
    add_instr(OP_EMIT, 8'd0);
    add_instr(OP_EMITDEC, 8'd0);
    add_instr(OP_ADD, 8'd0);
    add_instr(OP_PUSH, 8'd255);
    add_instr(OP_SWAP, 8'd0);
    add_instr(OP_ADD, 8'd255);
    add_instr(OP_PUSH, 8'd0);
    add_instr(OP_SWAP, 8'd0);
    add_instr(OP_EMITDEC, 8'd0);
    add_instr(OP_EMITDEC, 8'd0);
    add_instr(OP_PUSH, 8'd200);
    add_instr(OP_PUSH, 8'd100);
    add_instr(OP_ADD, 8'd0);
    add_instr(OP_EMITDEC, 8'd0);
    add_instr(OP_PUSH, 8'd9);
    add_instr(OP_EMITDEC, 8'd0);
    add_instr(OP_PUSH, 8'd10);
    add_instr(OP_EMITDEC, 8'd0);
    add_instr(OP_PUSH, 8'd99);
    add_instr(OP_EMITDEC, 8'd0);
    add_instr(OP_PUSH, 8'd199);
    add_instr(OP_EMIT, 8'd0);
    add_instr(OP_NOP, 8'hAA);
    add_instr(OP_UNUSED, 8'h55);

    // Fill past the top for an overflow, then empty the stack with digit output.
    next_waits = 1'b1;
    while (gen_depth < DEPTH) add_instr(OP_PUSH, rand_byte());
    add_instr(OP_PUSH, rand_byte());
    while (gen_depth > 0) add_instr(OP_EMITDEC, rand_byte());

    // Random segments of mixed instructions.
    while (pending_instrs.size() < 165) begin
      next_waits = ($urandom_range(0, 7) == 0);
      seg = $urandom_range(0, 15);
      if (!press_done && pending_instrs.size() >= 55) begin
        // Back-to-back output-heavy stretch while the receiver holds off.
        press_done  = 1'b1;
        next_waits  = 1'b0;
        press_start = pending_instrs.size();
        repeat (15) begin
          add_instr(OP_PUSH, rand_byte());
          add_instr(OP_EMITDEC, rand_byte());
        end
        next_waits = 1'b1;
      end else if (seg == 0) begin
        while (gen_depth < DEPTH) add_instr(OP_PUSH, rand_byte());
        add_instr(OP_PUSH, rand_byte());
      end else if (seg == 1) begin
        while (gen_depth > 0) begin
          add_instr($urandom_range(0, 1) ? OP_EMIT : OP_EMITDEC, rand_byte());
        end
        add_instr($urandom_range(0, 1) ? OP_ADD : OP_SWAP, rand_byte());
      end else begin
        repeat (6) begin
          thr = (gen_depth < 2) ? 60 : (gen_depth > 13) ? 15 : 40;
          r = $urandom_range(0, 99);
          if (r < thr) fn = OP_PUSH;
          else if (r < 72) fn = OP_EMITDEC;
          else if (r < 82) fn = OP_EMIT;
          else if (r < 89) fn = OP_ADD;
          else if (r < 95) fn = OP_SWAP;
          else if (r < 98) fn = OP_NOP;
          else fn = OP_UNUSED;
          add_instr(fn, rand_byte());
        end
      end
    end

    // Halt, then show that nothing more comes out, not even from a second halt.
    add_instr(OP_PUSH, rand_byte());
    add_instr(OP_HALT, rand_byte());
    add_instr(OP_EMIT, rand_byte());
    add_instr(OP_PUSH, rand_byte());
    add_instr(OP_HALT, rand_byte());
    add_instr(OP_EMITDEC, rand_byte());
    add_instr(OP_ADD, rand_byte());
    item_total = pending_instrs.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken < item_total) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
